>>> rtl/core/crgf_pkg.sv
package crgf_pkg;

  localparam int unsigned MAX_DIM_DEF = 4096;

  localparam int unsigned DIM_W   = 13;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned INDEX_W = 24;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned NUM_CH  = COLOR_W / CH_W;
  localparam int unsigned T_W     = 8;
  localparam int unsigned NUM_W   = DIM_W + T_W;
  localparam int unsigned PROD_W  = 2 * (CH_W + 1);
  localparam int unsigned CLIP_W  = 18;

  localparam logic [DIM_W-1:0] SURF_W_RESET = DIM_W'(640);
  localparam logic [DIM_W-1:0] SURF_H_RESET = DIM_W'(480);

  typedef enum logic [0:0] {
    CFG_SURFACE_WIDTH  = 1'b0,
    CFG_SURFACE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_STEP        = 2'd0,
    KIND_START_EMPTY = 2'd1,
    KIND_START_RECT  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [DIM_W-1:0]   col;
    logic [DIM_W-1:0]   row;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [COLOR_W-1:0] top;
    logic [COLOR_W-1:0] bottom;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_DIV   = 3'd1,
    ST_MUL   = 3'd2,
    ST_BLEND = 3'd3,
    ST_ADDR  = 3'd4,
    ST_EMIT  = 3'd5
  } back_state_e;

endpackage

>>> rtl/core/crgf_if.sv
interface crgf_in_if import crgf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic signed [15:0] rect_w;
  logic signed [15:0] rect_h;
  logic [COLOR_W-1:0] top_color;
  logic [COLOR_W-1:0] bottom_color;

  modport source (
    output valid, command, rect_x, rect_y, rect_w, rect_h, top_color, bottom_color,
    input  ready
  );
  modport sink (
    input  valid, command, rect_x, rect_y, rect_w, rect_h, top_color, bottom_color,
    output ready
  );
endinterface

interface crgf_out_if import crgf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               write_valid;
  logic [INDEX_W-1:0] pixel_index;
  logic [COLOR_W-1:0] pixel_color;
  logic               last_write;
  logic               busy_res;

  modport source (
    output valid, write_valid, pixel_index, pixel_color, last_write, busy_res,
    input  ready
  );
  modport sink (
    input  valid, write_valid, pixel_index, pixel_color, last_write, busy_res,
    output ready
  );
endinterface

>>> rtl/core/clipped_rect_gradient_fill.sv
// Channel   Dir  Handshake          Payload
// in_ch     in   valid/ready        command, rect_x/y/w/h, top_color, bottom_color
// out_ch    out  valid/ready        write_valid, pixel_index, pixel_color,
//                                   last_write, busy_res
// cfg       in   cfg_we_i (no ack)  cfg_idx_i, cfg_wdata_i
//
// Each request yields one response. Start and idle steps are answered from the idle state of
// the back end; a pixel step passes an address stage and an emit stage, and on the first pixel
// of a row the row color is first rebuilt by a bit-serial divide, a multiply and a blend stage.
// Reset (rst_ni, async low) clears all control state; surface size resets to 640x480.
// A two-entry queue takes requests while the output register waits on out_ch.ready.
module clipped_rect_gradient_fill import crgf_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  crgf_in_if.sink          in_ch,
  crgf_out_if.source       out_ch,
  input  logic             cfg_we_i,
  input  cfg_reg_e         cfg_idx_i,
  input  logic [DIM_W-1:0] cfg_wdata_i
);

  logic             push, push_ready, job_valid, pop;
  job_t             push_job, head_job;
  logic [DIM_W-1:0] surf_w;

  crgf_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_o       (push),
    .job_o        (push_job),
    .push_ready_i (push_ready),
    .surf_w_o     (surf_w)
  );

  crgf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .ready_o (push_ready),
    .valid_o (job_valid),
    .job_o   (head_job),
    .pop_i   (pop)
  );

  crgf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .surf_w_i    (surf_w),
    .out_ch      (out_ch)
  );

endmodule

>>> rtl/core/crgf_front.sv
module crgf_front import crgf_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  crgf_in_if.sink          in_ch,
  input  logic             cfg_we_i,
  input  cfg_reg_e         cfg_idx_i,
  input  logic [DIM_W-1:0] cfg_wdata_i,
  output logic             push_o,
  output job_t             job_o,
  input  logic             push_ready_i,
  output logic [DIM_W-1:0] surf_w_o
);

  logic [DIM_W-1:0] surf_w_q, surf_w_d;
  logic [DIM_W-1:0] surf_h_q, surf_h_d;
  logic [DIM_W-1:0] cfg_val;

  logic signed [CLIP_W-1:0] x0, y0, w0, h0;
  logic signed [CLIP_W-1:0] x1, y1, w1, h1;
  logic signed [CLIP_W-1:0] w2, h2;
  logic signed [CLIP_W-1:0] sw_s, sh_s;
  logic                     empty;

  always_comb begin
    cfg_val = cfg_wdata_i;
    if (32'(cfg_wdata_i) > MAX_DIM) begin
      cfg_val = DIM_W'(MAX_DIM);
    end
    surf_w_d = surf_w_q;
    surf_h_d = surf_h_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SURFACE_WIDTH:  surf_w_d = cfg_val;
        CFG_SURFACE_HEIGHT: surf_h_d = cfg_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      surf_w_q <= SURF_W_RESET;
      surf_h_q <= SURF_H_RESET;
    end else begin
      surf_w_q <= surf_w_d;
      surf_h_q <= surf_h_d;
    end
  end

  // clip against the surface
  always_comb begin
    x0   = CLIP_W'(in_ch.rect_x);
    y0   = CLIP_W'(in_ch.rect_y);
    w0   = CLIP_W'(in_ch.rect_w);
    h0   = CLIP_W'(in_ch.rect_h);
    sw_s = signed'({{(CLIP_W-DIM_W){1'b0}}, surf_w_q});
    sh_s = signed'({{(CLIP_W-DIM_W){1'b0}}, surf_h_q});
    x1   = (x0 < 0) ? '0 : x0;
    w1   = (x0 < 0) ? (w0 + x0) : w0;
    y1   = (y0 < 0) ? '0 : y0;
    h1   = (y0 < 0) ? (h0 + y0) : h0;
    w2   = (x1 + w1 > sw_s) ? (sw_s - x1) : w1;
    h2   = (y1 + h1 > sh_s) ? (sh_s - y1) : h1;
    empty = (w0 <= 0) || (h0 <= 0) || (w2 <= 0) || (h2 <= 0);

    job_o.col    = x1[DIM_W-1:0];
    job_o.row    = y1[DIM_W-1:0];
    job_o.width  = w2[DIM_W-1:0];
    job_o.height = h2[DIM_W-1:0];
    job_o.top    = in_ch.top_color;
    job_o.bottom = in_ch.bottom_color;
    if (in_ch.command) begin
      job_o.kind = KIND_STEP;
    end else if (empty) begin
      job_o.kind = KIND_START_EMPTY;
    end else begin
      job_o.kind = KIND_START_RECT;
    end
  end

  assign in_ch.ready = push_ready_i;
  assign push_o      = in_ch.valid && push_ready_i;
  assign surf_w_o    = surf_w_q;

endmodule

>>> rtl/core/crgf_queue.sv
module crgf_queue import crgf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic ready_o,
  output logic valid_o,
  output job_t job_o,
  input  logic pop_i
);

  job_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/crgf_back.sv
module crgf_back import crgf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  job_t             job_i,
  output logic             pop_o,
  input  logic [DIM_W-1:0] surf_w_i,
  crgf_out_if.source       out_ch
);

  back_state_e state_q, state_d;

  logic               active_q;
  logic [DIM_W-1:0]   org_col_q, org_row_q, span_w_q, span_h_q, col_q, row_q;
  logic [COLOR_W-1:0] top_q, bot_q, row_color_q, row_color_d;
  logic [T_W-1:0]     t_q;
  logic [NUM_W-1:0]   rem_q;
  logic [2:0]         bit_q;
  logic signed [PROD_W-1:0] mix_q [NUM_CH];
  logic [2*DIM_W-1:0] addr_q;

  logic               out_valid_q;
  logic               wv_q, last_q, busy_q;
  logic [INDEX_W-1:0] idx_q;
  logic [COLOR_W-1:0] color_q;

  logic               out_free;
  logic               is_step, run_step;
  logic               take_zero, take_row, take_pix, emit;
  logic [DIM_W-1:0]   denom;
  logic [NUM_W-1:0]   div_sub;
  logic               div_ge;
  logic               col_end, row_end, last;
  logic [DIM_W-1:0]   abs_row, abs_col;
  logic [INDEX_W-1:0] pix_idx;

  assign out_free = !out_valid_q || out_ch.ready;
  assign is_step  = (job_i.kind == KIND_STEP);
  assign run_step = is_step && active_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i && out_free && run_step) begin
          state_d = (col_q == '0) ? ST_DIV : ST_ADDR;
        end
      end
      ST_DIV:   if (bit_q == 3'd0) state_d = ST_MUL;
      ST_MUL:   state_d = ST_BLEND;
      ST_BLEND: state_d = ST_ADDR;
      ST_ADDR:  state_d = ST_EMIT;
      ST_EMIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    take_zero = 1'b0;
    take_row  = 1'b0;
    take_pix  = 1'b0;
    emit      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i && out_free) begin
          take_zero = !run_step;
          take_row  = run_step && (col_q == '0);
          take_pix  = run_step && (col_q != '0);
        end
      end
      ST_EMIT: emit = out_free;
      default: ;
    endcase
  end

  assign pop_o = take_zero || take_row || take_pix;

  // t = row*255/(H-1), one quotient bit per cycle
  assign denom   = (span_h_q > DIM_W'(1)) ? (span_h_q - DIM_W'(1)) : DIM_W'(1);
  assign div_sub = NUM_W'({{T_W{1'b0}}, denom} << bit_q);
  assign div_ge  = (rem_q >= div_sub);

  always_comb begin
    logic [PROD_W-1:0] mag;
    logic [CH_W-1:0]   qt, c1;
    row_color_d = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      c1  = top_q[k*CH_W +: CH_W];
      mag = mix_q[k][PROD_W-1] ? PROD_W'(-mix_q[k]) : PROD_W'(mix_q[k]);
      qt  = CH_W'((mag + PROD_W'(1) + (mag >> CH_W)) >> CH_W);
      row_color_d[k*CH_W +: CH_W] = mix_q[k][PROD_W-1] ? (c1 - qt) : (c1 + qt);
    end
  end

  assign abs_row = org_row_q + row_q;
  assign abs_col = org_col_q + col_q;
  assign pix_idx = addr_q[INDEX_W-1:0] + INDEX_W'(abs_col);
  assign col_end = ({1'b0, col_q} + 1'b1) >= {1'b0, span_w_q};
  assign row_end = ({1'b0, row_q} + 1'b1) >= {1'b0, span_h_q};
  assign last    = col_end && row_end;

  always_ff @(posedge clk_i) begin
    if (take_row) begin
      rem_q <= (NUM_W'(row_q) << T_W) - NUM_W'(row_q);
      t_q   <= '0;
    end else if (state_q == ST_DIV) begin
      if (div_ge) begin
        rem_q <= rem_q - div_sub;
      end
      t_q <= {t_q[T_W-2:0], div_ge};
    end
    if (state_q == ST_MUL) begin
      for (int k = 0; k < NUM_CH; k++) begin
        mix_q[k] <= (signed'({1'b0, bot_q[k*CH_W +: CH_W]})
                   - signed'({1'b0, top_q[k*CH_W +: CH_W]}))
                   * signed'({1'b0, t_q});
      end
    end
    if (state_q == ST_ADDR) begin
      addr_q <= abs_row * surf_w_i;
    end
    if (take_zero || emit) begin
      idx_q   <= take_zero ? '0 : pix_idx;
      color_q <= take_zero ? '0 : row_color_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      org_col_q   <= '0;
      org_row_q   <= '0;
      span_w_q    <= '0;
      span_h_q    <= '0;
      col_q       <= '0;
      row_q       <= '0;
      top_q       <= '0;
      bot_q       <= '0;
      row_color_q <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
      wv_q        <= 1'b0;
      last_q      <= 1'b0;
      busy_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take_zero && !is_step) begin
        active_q    <= (job_i.kind == KIND_START_RECT);
        col_q       <= '0;
        row_q       <= '0;
        top_q       <= job_i.top;
        bot_q       <= job_i.bottom;
        row_color_q <= job_i.top;
        if (job_i.kind == KIND_START_RECT) begin
          org_col_q <= job_i.col;
          org_row_q <= job_i.row;
          span_w_q  <= job_i.width;
          span_h_q  <= job_i.height;
        end
      end
      if (take_row) begin
        bit_q <= 3'd7;
      end else if (state_q == ST_DIV) begin
        bit_q <= bit_q - 3'd1;
      end
      if (state_q == ST_BLEND) begin
        row_color_q <= row_color_d;
      end
      if (emit) begin
        if (last) begin
          active_q <= 1'b0;
          col_q    <= '0;
          row_q    <= '0;
        end else if (col_end) begin
          col_q <= '0;
          row_q <= row_q + DIM_W'(1);
        end else begin
          col_q <= col_q + DIM_W'(1);
        end
      end
      if (take_zero || emit) begin
        out_valid_q <= 1'b1;
        wv_q        <= emit;
        last_q      <= emit && last;
        busy_q      <= emit && !last;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.write_valid = wv_q;
  assign out_ch.pixel_index = idx_q;
  assign out_ch.pixel_color = color_q;
  assign out_ch.last_write  = last_q;
  assign out_ch.busy_res    = busy_q;

endmodule

>>> bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import crgf_pkg::*;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_STEP    = 1'b1;
  localparam int   DIM_CAP     = MAX_DIM_DEF;
  localparam int   CYCLE_LIMIT = 400000;
  localparam int   PRESSURE_CYCLES = 300;

  typedef struct packed {
    logic               command;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic [31:0]        top;
    logic [31:0]        bottom;
  } fill_req_t;

  typedef struct packed {
    logic        write_valid;
    logic [23:0] pixel_index;
    logic [31:0] pixel_color;
    logic        last_write;
    logic        busy_res;
  } fill_res_t;

  typedef struct packed {
    fill_req_t req;
    logic      has_want;
    fill_res_t want;
  } dir_row_t;

  localparam fill_res_t NO_WRITE = '0;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  cfg_reg_e         cfg_idx_i;
  logic [DIM_W-1:0] cfg_wdata_i;

  crgf_in_if  in_ch ();
  crgf_out_if out_ch ();

  clipped_rect_gradient_fill dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // engine model state
  int          surf_w = 640;
  int          surf_h = 480;
  bit          eng_active;
  int          eng_col0, eng_row0, eng_span_w, eng_span_h, eng_col, eng_row;
  logic [31:0] eng_top, eng_bottom, eng_row_color;

  fill_res_t pixel_expect_q [$];
  int        err_count;
  int        sent_count;
  int        res_seen;
  int        cycle_count;
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        pressure_req;
  int        hold_left;

  dir_row_t dir_tab [25] = '{
    '{'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0}, 1'b1, NO_WRITE},
    '{'{CMD_START, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 32'hFFFFFFFF, 32'h0}, 1'b1, NO_WRITE},
    '{'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0}, 1'b1,
      '{1'b1, 24'd0, 32'hFFFFFFFF, 1'b1, 1'b0}},
    '{'{CMD_STEP, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
      1'b1, NO_WRITE},
    '{'{CMD_START, 16'sd0, 16'sd0, 16'sd0, 16'sd5, 32'h11223344, 32'h55667788}, 1'b1, NO_WRITE},
    '{'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0}, 1'b1, NO_WRITE},
    '{'{CMD_START, 16'sd0, 16'sd0, 16'sh8000, 16'sh7FFF, 32'h0, 32'hFFFFFFFF}, 1'b1, NO_WRITE},
    '{'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0}, 1'b1, NO_WRITE},
    '{'{CMD_START, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 32'hFFFFFFFF, 32'h0},
      1'b1, NO_WRITE},
    '{'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0}, 1'b1, NO_WRITE},
    '{'{CMD_START, 16'sh7FFF, 16'sd0, 16'sd5, 16'sd5, 32'hA5A5A5A5, 32'h5A5A5A5A},
      1'b1, NO_WRITE},
    '{'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0}, 1'b1, NO_WRITE},
    '{'{CMD_START, 16'sd639, 16'sd479, 16'sh7FFF, 16'sh7FFF, 32'h00FF00FF, 32'hFF00FF00},
      1'b1, NO_WRITE},
    '{'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0}, 1'b1,
      '{1'b1, 24'd307199, 32'h00FF00FF, 1'b1, 1'b0}},
    '{'{CMD_START, -16'sd2, -16'sd3, 16'sd5, 16'sd6, 32'h00000000, 32'hFFFFFFFF},
      1'b1, NO_WRITE},
    '{'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0}, 1'b0, NO_WRITE},
    '{'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0}, 1'b0, NO_WRITE},
    '{'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0}, 1'b0, NO_WRITE},
    '{'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0}, 1'b0, NO_WRITE},
    '{'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0}, 1'b0, NO_WRITE},
    '{'{CMD_START, 16'sd10, 16'sd20, 16'sd4, 16'sd2, 32'h12345678, 32'h12345678},
      1'b1, NO_WRITE},
    '{'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0}, 1'b0, NO_WRITE},
    '{'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0}, 1'b0, NO_WRITE},
    '{'{CMD_START, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh7FFF, 32'h80808080, 32'h7F7F7F7F},
      1'b1, NO_WRITE},
    '{'{CMD_STEP, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0}, 1'b0, NO_WRITE}
  };

  function automatic logic [31:0] row_shade(int j);
    int          denom, t, c1, c2, c;
    logic [31:0] color;
    denom = (eng_span_h > 1) ? eng_span_h - 1 : 1;
    t     = (j * 255) / denom;
    color = '0;
    for (int sh = 0; sh < 32; sh += 8) begin
      c1 = (eng_top >> sh) & 32'hFF;
      c2 = (eng_bottom >> sh) & 32'hFF;
      c  = c1 + ((c2 - c1) * t) / 255;
      color |= (32'(c) & 32'hFF) << sh;
    end
    return color;
  endfunction

  function automatic fill_res_t fill_predict(fill_req_t r);
    fill_res_t o;
    int        x, y, w, h;
    longint    idx;
    bit        last;
    o = '0;
    if (r.command == CMD_START) begin
      x = r.x;
      y = r.y;
      w = r.w;
      h = r.h;
      eng_active = 1'b0;
      eng_col    = 0;
      eng_row    = 0;
      eng_top    = r.top;
      eng_bottom = r.bottom;
      if (w > 0 && h > 0) begin
        if (x < 0) begin
          w += x;
          x = 0;
        end
        if (y < 0) begin
          h += y;
          y = 0;
        end
        if (x + w > surf_w) w = surf_w - x;
        if (y + h > surf_h) h = surf_h - y;
        if (w > 0 && h > 0) begin
          eng_col0      = x;
          eng_row0      = y;
          eng_span_w    = w;
          eng_span_h    = h;
          eng_row_color = row_shade(0);
          eng_active    = 1'b1;
        end
      end
    end else if (eng_active) begin
      if (eng_col == 0) eng_row_color = row_shade(eng_row);
      idx  = longint'(eng_row0 + eng_row) * surf_w + longint'(eng_col0 + eng_col);
      last = (eng_col + 1 >= eng_span_w) && (eng_row + 1 >= eng_span_h);
      o.write_valid = 1'b1;
      o.pixel_index = idx[23:0];
      o.pixel_color = eng_row_color;
      o.last_write  = last;
      o.busy_res    = !last;
      if (last) begin
        eng_active = 1'b0;
        eng_col    = 0;
        eng_row    = 0;
      end else if (eng_col + 1 >= eng_span_w) begin
        eng_col = 0;
        eng_row++;
      end else begin
        eng_col++;
      end
    end
    return o;
  endfunction

  function automatic fill_req_t random_step();
    fill_req_t r;
    r.command = CMD_STEP;
    r.x       = 16'($urandom());
    r.y       = 16'($urandom());
    r.w       = 16'($urandom());
    r.h       = 16'($urandom());
    r.top     = $urandom();
    r.bottom  = $urandom();
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    err_count++;
    $display("mismatch at write %0d: %s got %0h want %0h", res_seen, what, got, want);
  endtask

  task automatic send_request(fill_req_t r, logic has_want, fill_res_t want);
    fill_res_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= r.command;
    in_ch.rect_x       <= r.x;
    in_ch.rect_y       <= r.y;
    in_ch.rect_w       <= r.w;
    in_ch.rect_h       <= r.h;
    in_ch.top_color    <= r.top;
    in_ch.bottom_color <= r.bottom;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pred = fill_predict(r);
    pixel_expect_q.push_back(has_want ? want : pred);
    sent_count++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pixel_expect_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_surface(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SURFACE_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SURFACE_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    surf_w = (w > DIM_CAP) ? DIM_CAP : int'(w);
    surf_h = (h > DIM_CAP) ? DIM_CAP : int'(h);
  endtask

  task automatic random_traffic(int n);
    int        stop_at, pick, x, y, w, h, steps;
    fill_req_t r;
    stop_at = sent_count + n;
    // carry on with whatever rectangle is still open
    repeat (3) send_request(random_step(), 1'b0, NO_WRITE);
    while (sent_count < stop_at) begin
      r.command = CMD_START;
      r.top     = $urandom();
      r.bottom  = ($urandom_range(5) == 0) ? r.top : $urandom();
      pick      = $urandom_range(99);
      if (pick < 25) begin
        r.x = 16'($urandom());
        r.y = 16'($urandom());
        r.w = 16'($urandom());
        r.h = 16'($urandom());
        send_request(r, 1'b0, NO_WRITE);
        steps = $urandom_range(4);
      end else begin
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 6);
        if (pick < 33) begin
          w = 1;
          h = $urandom_range(2, 200);
        end else if (pick < 40) begin
          w = $urandom_range(7, 64);
          h = $urandom_range(1, 2);
        end
        x = ($urandom_range(3) == 0) ? surf_w - int'($urandom_range(6))
                                     : int'($urandom_range(surf_w + 2)) - 4;
        y = ($urandom_range(3) == 0) ? surf_h - int'($urandom_range(6))
                                     : int'($urandom_range(surf_h + 2)) - 4;
        r.x = 16'(x);
        r.y = 16'(y);
        r.w = 16'(w);
        r.h = 16'(h);
        send_request(r, 1'b0, NO_WRITE);
        steps = eng_active ? eng_span_w * eng_span_h : 0;
        pick  = $urandom_range(9);
        if (pick == 0) steps = $urandom_range(steps);
        else if (pick == 1) steps += $urandom_range(1, 3);
      end
      repeat (steps) send_request(random_step(), 1'b0, NO_WRITE);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (pressure_req) begin
        hold_left    = PRESSURE_CYCLES;
        pressure_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    fill_res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      res_seen++;
      if (pixel_expect_q.size() == 0) begin
        report_mismatch("unexpected write", out_ch.pixel_index, 0);
      end else begin
        want = pixel_expect_q.pop_front();
        if (out_ch.write_valid !== want.write_valid)
          report_mismatch("write_valid", out_ch.write_valid, want.write_valid);
        if (out_ch.pixel_index !== want.pixel_index)
          report_mismatch("pixel_index", out_ch.pixel_index, want.pixel_index);
        if (out_ch.pixel_color !== want.pixel_color)
          report_mismatch("pixel_color", out_ch.pixel_color, want.pixel_color);
        if (out_ch.last_write !== want.last_write)
          report_mismatch("last_write", out_ch.last_write, want.last_write);
        if (out_ch.busy_res !== want.busy_res)
          report_mismatch("busy_res", out_ch.busy_res, want.busy_res);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_STEP;
    in_ch.rect_x       = '0;
    in_ch.rect_y       = '0;
    in_ch.rect_w       = '0;
    in_ch.rect_h       = '0;
    in_ch.top_color    = '0;
    in_ch.bottom_color = '0;
    out_ch.ready       = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_SURFACE_WIDTH;
    cfg_wdata_i        = '0;
    send_idle_pct      = 30;
    recv_idle_pct      = 54;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_request(dir_tab[i].req, dir_tab[i].has_want, dir_tab[i].want);
    settle();

    // width change lands while the full-surface fill is still open
    set_surface(13'd4096, 13'd4096);
    random_traffic(500);
    settle();

    send_idle_pct = 54;
    recv_idle_pct = 30;
    set_surface(13'd8191, 13'd1);
    random_traffic(400);
    settle();
    set_surface(13'd0, 13'd0);
    random_traffic(60);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_surface(13'd17, 13'd33);
    pressure_req = 1'b1;
    random_traffic(500);
    settle();
    set_surface(13'd1, 13'd8191);
    random_traffic(470);
    settle();

    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
